// ----- hw/rtl/tbps_pkg.sv -----
// Shared types, codes and reset constants for the token bucket packet shaper.
// Used by every module of the shaper; depends on nothing.
`default_nettype none

package tbps_pkg;

    // Field widths fixed by the interface.
    localparam int ReqW   = 2;
    localparam int IdW    = 16;
    localparam int NeedW  = 10;
    localparam int SvcW   = 16;
    localparam int EventW = 3;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    // Default number of packet slots in the wait queue.
    localparam int QueueDepthDefault = 16;

    // Configuration reset values.
    localparam logic [NeedW-1:0] BucketDepthReset     = 10'd10;
    localparam logic [IdW-1:0]   PacketsExpectedReset = 16'd20;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgBucketDepth     = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgPacketsExpected = 2'd1;

    // Request codes on the input channel.
    localparam logic [ReqW-1:0] ReqTick    = 2'd0;
    localparam logic [ReqW-1:0] ReqArrive  = 2'd1;
    localparam logic [ReqW-1:0] ReqRestart = 2'd2;

    // Event codes on the result channel.
    typedef enum logic [EventW-1:0] {
        EV_TOKEN_ADDED   = 3'd0,
        EV_TOKEN_DROPPED = 3'd1,
        EV_PACKET_DROP   = 3'd2,
        EV_QUEUED        = 3'd3,
        EV_RELEASED      = 3'd4,
        EV_QUEUE_FULL    = 3'd5,
        EV_RESTARTED     = 3'd6
    } t_event;

    // Classified command handed from the front to the back.
    typedef enum logic [1:0] {
        K_TICK,
        K_ARRIVE,
        K_OVERSIZE,
        K_RESTART
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IdW-1:0]     id;
        logic [NeedW-1:0]   need;
        logic [SvcW-1:0]    svc;
    } t_cmd;

    // One waiting packet in the wait queue.
    typedef struct packed {
        logic [IdW-1:0]     id;
        logic [NeedW-1:0]   need;
        logic [SvcW-1:0]    svc;
    } t_slot;

    // Configuration values seen by the front and the back.
    typedef struct packed {
        logic [NeedW-1:0]   bucket_depth;
        logic [IdW-1:0]     packets_expected;
    } t_cfg;

    // Back sequencer states.
    typedef enum logic {
        B_EXEC,
        B_CHECK
    } t_bstate;

endpackage : tbps_pkg

`default_nettype wire

// ----- hw/rtl/tbps_front.sv -----
// Front stage: accepts requests, classifies them and holds one command.
// Depends on tbps_pkg for the command type and request codes.
`default_nettype none

module tbps_front
    import tbps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [ReqW-1:0]   i_req_type,
    input  wire logic [IdW-1:0]    i_packet_id,
    input  wire logic [NeedW-1:0]  i_tokens_needed,
    input  wire logic [SvcW-1:0]   i_service_time,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_ready,
    output t_cmd                   o_cmd
);

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic accept;
    logic keep;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign accept      = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Classify the request; an unused request code is taken and discarded.
    always_comb begin
        keep       = 1'b1;
        n_cmd.id   = i_packet_id;
        n_cmd.need = i_tokens_needed;
        n_cmd.svc  = i_service_time;
        unique case (i_req_type)
            ReqTick:    n_cmd.kind = K_TICK;
            ReqArrive: begin
                if (i_tokens_needed > i_cfg.bucket_depth) begin
                    n_cmd.kind = K_OVERSIZE;
                end else begin
                    n_cmd.kind = K_ARRIVE;
                end
            end
            ReqRestart: n_cmd.kind = K_RESTART;
            default: begin
                n_cmd.kind = K_TICK;
                keep       = 1'b0;
            end
        endcase
    end

    // Valid flag of the holding register.
    always_comb begin
        if (accept) begin
            n_valid = keep;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule : tbps_front

`default_nettype wire

// ----- hw/rtl/tbps_cmdq.sv -----
// Two-entry command queue that decouples the front from the back.
// Depends on tbps_pkg for the command type.
`default_nettype none

module tbps_cmdq
    import tbps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_cmd  i_push_cmd,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_cmd       o_pop_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Fill level follows pushes and pops.
    always_comb begin
        unique case ({push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule : tbps_cmdq

`default_nettype wire

// ----- hw/rtl/tbps_back.sv -----
// Back stage: bucket and wait queue state, release sequencer and result register.
// Depends on tbps_pkg for command, slot, event and state types.
`default_nettype none

module tbps_back
    import tbps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    localparam int IW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_cmd_valid,
    output logic                    o_cmd_ready,
    input  wire t_cmd               i_cmd,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [EventW-1:0]       o_event_res,
    output logic [IdW-1:0]          o_out_packet_id,
    output logic [SvcW-1:0]         o_out_service_time,
    output logic [NeedW-1:0]        o_token_level,
    output logic [CW-1:0]           o_queue_level,
    output logic [IdW-1:0]          o_packets_left,
    output logic                    o_last
);

    // Shaper state.
    t_bstate          r_state, n_state;
    logic [NeedW-1:0] r_token, n_token;
    logic [IdW-1:0]   r_rem, n_rem;
    logic [IW-1:0]    r_head, n_head;
    logic [IW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;

    // Wait queue memory and its registered head read.
    t_slot            mem [QUEUE_DEPTH];
    t_slot            r_rd;
    logic             mem_we;
    t_slot            wslot;

    // Result register.
    logic             r_ovalid;
    t_event           r_event, n_event;
    logic [IdW-1:0]   r_pid, n_pid;
    logic [SvcW-1:0]  r_svc, n_svc;
    logic [NeedW-1:0] r_tlev;
    logic [CW-1:0]    r_qlev;
    logic [IdW-1:0]   r_left;
    logic             r_last, n_last;

    logic             out_free;
    logic             fire;
    logic             release_ok;
    logic [NeedW-1:0] head_need;
    logic [IdW-1:0]   rem_dec;
    logic [IW-1:0]    tail_inc, head_inc;

    assign out_free    = !r_ovalid || i_ready;
    assign fire        = (r_state == B_CHECK) ? out_free : (i_cmd_valid && out_free);
    assign o_cmd_ready = (r_state == B_EXEC) && out_free;
    assign rem_dec     = (r_rem != '0) ? (r_rem - IdW'(1)) : r_rem;
    assign tail_inc    = (r_tail == IW'(QUEUE_DEPTH - 1)) ? '0 : (r_tail + IW'(1));
    assign head_inc    = (r_head == IW'(QUEUE_DEPTH - 1)) ? '0 : (r_head + IW'(1));
    // With an empty queue the packet just queued is the head.
    assign head_need   = (r_count == '0) ? i_cmd.need : r_rd.need;

    // Next sequencer state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_EXEC: begin
                if (fire && release_ok) begin
                    n_state = B_CHECK;
                end
            end
            B_CHECK: begin
                if (fire) begin
                    n_state = B_EXEC;
                end
            end
            default: n_state = B_EXEC;
        endcase
    end

    // State updates and the result of this cycle.
    always_comb begin
        n_token    = r_token;
        n_rem      = r_rem;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        mem_we     = 1'b0;
        wslot.id   = i_cmd.id;
        wslot.need = i_cmd.need;
        wslot.svc  = i_cmd.svc;
        release_ok = 1'b0;
        n_event    = EV_TOKEN_DROPPED;
        n_pid      = '0;
        n_svc      = '0;
        n_last     = 1'b1;
        unique case (r_state)
            B_EXEC: begin
                unique case (i_cmd.kind)
                    K_TICK: begin
                        if (r_token < i_cfg.bucket_depth && r_rem != '0) begin
                            n_token    = r_token + NeedW'(1);
                            n_event    = EV_TOKEN_ADDED;
                            release_ok = (r_count != '0) && (n_token >= r_rd.need);
                        end else begin
                            n_event = EV_TOKEN_DROPPED;
                        end
                    end
                    K_OVERSIZE: begin
                        n_rem   = rem_dec;
                        n_event = EV_PACKET_DROP;
                        n_pid   = i_cmd.id;
                    end
                    K_ARRIVE: begin
                        n_pid = i_cmd.id;
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_rem   = rem_dec;
                            n_event = EV_QUEUE_FULL;
                        end else begin
                            mem_we     = fire;
                            n_tail     = tail_inc;
                            n_count    = r_count + CW'(1);
                            n_event    = EV_QUEUED;
                            release_ok = (r_token >= head_need);
                        end
                    end
                    K_RESTART: begin
                        n_rem   = i_cfg.packets_expected;
                        n_event = EV_RESTARTED;
                    end
                    default: n_event = EV_TOKEN_DROPPED;
                endcase
                n_last = !release_ok;
            end
            B_CHECK: begin
                n_token = r_token - r_rd.need;
                n_head  = head_inc;
                n_count = r_count - CW'(1);
                n_rem   = rem_dec;
                n_event = EV_RELEASED;
                n_pid   = r_rd.id;
                n_svc   = r_rd.svc;
            end
            default: n_last = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_EXEC;
            r_token  <= '0;
            r_rem    <= PacketsExpectedReset;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_token <= n_token;
                r_rem   <= n_rem;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (fire) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_event <= n_event;
            r_pid   <= n_pid;
            r_svc   <= n_svc;
            r_tlev  <= n_token;
            r_qlev  <= n_count;
            r_left  <= n_rem;
            r_last  <= n_last;
        end
    end

    // Queue memory: write at the tail, read the next head with write forwarding.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_tail] <= wslot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && (r_tail == (fire ? n_head : r_head))) begin
            r_rd <= wslot;
        end else begin
            r_rd <= mem[fire ? n_head : r_head];
        end
    end

    assign o_valid            = r_ovalid;
    assign o_event_res        = r_event;
    assign o_out_packet_id    = r_pid;
    assign o_out_service_time = r_svc;
    assign o_token_level      = r_tlev;
    assign o_queue_level      = r_qlev;
    assign o_packets_left     = r_left;
    assign o_last             = r_last;

endmodule : tbps_back

`default_nettype wire

// ----- hw/rtl/token_bucket_packet_shaper_unit.sv -----
// Top level of the token bucket packet shaper: configuration registers,
// front, command queue and back. Depends on tbps_pkg and the tbps_* modules.
//
//  Channel   Direction  Handshake               Payload
//  request   in         i_valid / o_ready       i_req_type, i_packet_id,
//                                               i_tokens_needed, i_service_time
//  result    out        o_valid / i_ready       o_event_res .. o_last
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A request is executed by the back in state B_EXEC; one that also releases the
// head packet takes the back through B_CHECK before the next command is taken.
// The back sequencer and its single result register set that pace. A request is
// held in the front register, then in the command queue, and its first result is
// loaded into the result register. Synchronous reset clears all control state;
// the wait queue memory needs no clearing pass. A stalled result holds the back,
// while the front and the two-entry queue keep taking requests until full.
`default_nettype none

module token_bucket_packet_shaper_unit
    import tbps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [ReqW-1:0]      i_req_type,
    input  wire logic [IdW-1:0]       i_packet_id,
    input  wire logic [NeedW-1:0]     i_tokens_needed,
    input  wire logic [SvcW-1:0]      i_service_time,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [EventW-1:0]         o_event_res,
    output logic [IdW-1:0]            o_out_packet_id,
    output logic [SvcW-1:0]           o_out_service_time,
    output logic [NeedW-1:0]          o_token_level,
    output logic [CW-1:0]             o_queue_level,
    output logic [IdW-1:0]            o_packets_left,
    output logic                      o_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [CfgDataW-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    logic f_valid, f_ready;
    t_cmd f_cmd;
    logic q_valid, q_ready;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bucket_depth     <= BucketDepthReset;
            r_cfg.packets_expected <= PacketsExpectedReset;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CfgBucketDepth) begin
                r_cfg.bucket_depth <= i_cfg_data[NeedW-1:0];
            end else if (i_cfg_index == CfgPacketsExpected) begin
                r_cfg.packets_expected <= i_cfg_data[IdW-1:0];
            end
        end
    end

    tbps_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_packet_id     (i_packet_id),
        .i_tokens_needed (i_tokens_needed),
        .i_service_time  (i_service_time),
        .o_cmd_valid     (f_valid),
        .i_cmd_ready     (f_ready),
        .o_cmd           (f_cmd)
    );

    tbps_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    tbps_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd_valid        (q_valid),
        .o_cmd_ready        (q_ready),
        .i_cmd              (q_cmd),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_event_res        (o_event_res),
        .o_out_packet_id    (o_out_packet_id),
        .o_out_service_time (o_out_service_time),
        .o_token_level      (o_token_level),
        .o_queue_level      (o_queue_level),
        .o_packets_left     (o_packets_left),
        .o_last             (o_last)
    );

endmodule : token_bucket_packet_shaper_unit

`default_nettype wire

// ----- test/tb_token_bucket_packet_shaper_unit.sv -----
// Self-checking testbench for the token bucket packet shaper unit.
// Depends on tbps_pkg and token_bucket_packet_shaper_unit; predicts every event in-line.
`default_nettype none

module tb_token_bucket_packet_shaper_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tbps_pkg::*;

    localparam int QD    = QueueDepthDefault;
    localparam int QLW   = $clog2(QD + 1);
    localparam int PTRW  = $clog2(QD);
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 2000;

    // Request code that the block ignores.
    localparam logic [ReqW-1:0] ReqUnused = 2'd3;

    typedef struct {
        logic [ReqW-1:0]  req;
        logic [IdW-1:0]   id;
        logic [NeedW-1:0] need;
        logic [SvcW-1:0]  svc;
    } t_request;

    typedef struct {
        t_event           ev;
        logic [IdW-1:0]   id;
        logic [SvcW-1:0]  svc;
        logic [NeedW-1:0] tokens;
        logic [QLW-1:0]   qlevel;
        logic [IdW-1:0]   left;
        logic             last;
    } t_shaper_event;

    // Block inputs, all known from time zero.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [ReqW-1:0]     i_req_type = '0;
    logic [IdW-1:0]      i_packet_id = '0;
    logic [NeedW-1:0]    i_tokens_needed = '0;
    logic [SvcW-1:0]     i_service_time = '0;
    logic                i_ready = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    wire logic             o_ready;
    wire logic             o_valid;
    wire logic [EventW-1:0] o_event_res;
    wire logic [IdW-1:0]   o_out_packet_id;
    wire logic [SvcW-1:0]  o_out_service_time;
    wire logic [NeedW-1:0] o_token_level;
    wire logic [QLW-1:0]   o_queue_level;
    wire logic [IdW-1:0]   o_packets_left;
    wire logic             o_last;
    wire logic             o_cfg_ready;

    token_bucket_packet_shaper_unit #(
        .QUEUE_DEPTH(QD)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_packet_id        (i_packet_id),
        .i_tokens_needed    (i_tokens_needed),
        .i_service_time     (i_service_time),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_event_res        (o_event_res),
        .o_out_packet_id    (o_out_packet_id),
        .o_out_service_time (o_out_service_time),
        .o_token_level      (o_token_level),
        .o_queue_level      (o_queue_level),
        .o_packets_left     (o_packets_left),
        .o_last             (o_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // Stimulus and expectation stores.
    t_request      pending_reqs[$];
    t_shaper_event due_events[$];

    // Shaper state as predicted by the testbench.
    logic [NeedW-1:0] cfg_depth = BucketDepthReset;
    logic [IdW-1:0]   cfg_packets = PacketsExpectedReset;
    logic [NeedW-1:0] bkt_tokens;
    logic [IdW-1:0]   pkts_left;
    t_slot            slot_mem [QD];
    logic [PTRW-1:0]  slot_head;
    logic [PTRW-1:0]  slot_tail;
    logic [QLW-1:0]   slot_count;

    // Events produced by one request, before they are queued.
    t_shaper_event step_events [2];
    int            step_n;

    // Traffic shaping of both channels.
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;
    logic req_accepted = 1'b0;

    // Run statistics.
    int errors = 0;
    int reqs_taken = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int settings_run = 0;
    int n_released = 0;
    int n_pkt_drops = 0;
    int n_full_drops = 0;
    int n_tok_drops = 0;
    int idle_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Records one event with the state as it stands now.
    task automatic note_event(input t_event ev, input logic [IdW-1:0] id,
                              input logic [SvcW-1:0] svc);
        step_events[step_n].ev     = ev;
        step_events[step_n].id     = id;
        step_events[step_n].svc    = svc;
        step_events[step_n].tokens = bkt_tokens;
        step_events[step_n].qlevel = slot_count;
        step_events[step_n].left   = pkts_left;
        step_events[step_n].last   = 1'b0;
        step_n++;
    endtask

    // The remaining packet count never wraps below zero.
    task automatic count_down_left();
        if (pkts_left != '0)
            pkts_left = pkts_left - 1'b1;
    endtask

    // Releases the head packet when the bucket covers its need.
    task automatic release_head();
        t_slot hs;
        if (slot_count != '0) begin
            hs = slot_mem[slot_head];
            if (bkt_tokens >= hs.need) begin
                bkt_tokens = bkt_tokens - hs.need;
                slot_head  = slot_head + 1'b1;
                slot_count = slot_count - 1'b1;
                count_down_left();
                note_event(EV_RELEASED, hs.id, hs.svc);
            end
        end
    endtask

    // Works out the events caused by one accepted request and queues them.
    task automatic shape_request(input t_request r);
        step_n = 0;
        case (r.req)
            ReqTick: begin
                if (bkt_tokens < cfg_depth && pkts_left != '0) begin
                    bkt_tokens = bkt_tokens + 1'b1;
                    note_event(EV_TOKEN_ADDED, '0, '0);
                    release_head();
                end else begin
                    note_event(EV_TOKEN_DROPPED, '0, '0);
                end
            end
            ReqArrive: begin
                if (r.need > cfg_depth) begin
                    count_down_left();
                    note_event(EV_PACKET_DROP, r.id, '0);
                end else if (slot_count >= QD) begin
                    count_down_left();
                    note_event(EV_QUEUE_FULL, r.id, '0);
                end else begin
                    slot_mem[slot_tail] = '{id: r.id, need: r.need, svc: r.svc};
                    slot_tail  = slot_tail + 1'b1;
                    slot_count = slot_count + 1'b1;
                    note_event(EV_QUEUED, r.id, '0);
                    release_head();
                end
            end
            ReqRestart: begin
                pkts_left = cfg_packets;
                note_event(EV_RESTARTED, '0, '0);
            end
            default: ;
        endcase
        if (step_n > 0) begin
            step_events[step_n - 1].last = 1'b1;
            for (int k = 0; k < step_n; k++)
                due_events.push_back(step_events[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Accepted requests feed the predictor; accepted results are checked in order.
    always @(posedge i_clk) begin
        t_shaper_event want;
        t_request      r;
        if (!i_rst_n) begin
            req_accepted = 1'b0;
            bkt_tokens   = '0;
            pkts_left    = PacketsExpectedReset;
            slot_head    = '0;
            slot_tail    = '0;
            slot_count   = '0;
        end else begin
            req_accepted = i_valid && o_ready;
            if (req_accepted) begin
                r = '{req: i_req_type, id: i_packet_id, need: i_tokens_needed,
                      svc: i_service_time};
                shape_request(r);
                reqs_taken++;
            end
            if (o_valid && i_ready) begin
                if (due_events.size() == 0) begin
                    $error("result transaction with nothing expected: event %0d",
                           o_event_res);
                    errors++;
                end else begin
                    want = due_events.pop_front();
                    check_field("event_res", 32'(want.ev), 32'(o_event_res));
                    check_field("out_packet_id", 32'(want.id), 32'(o_out_packet_id));
                    check_field("out_service_time", 32'(want.svc),
                                32'(o_out_service_time));
                    check_field("token_level", 32'(want.tokens), 32'(o_token_level));
                    check_field("queue_level", 32'(want.qlevel), 32'(o_queue_level));
                    check_field("packets_left", 32'(want.left), 32'(o_packets_left));
                    check_field("last", 32'(want.last), 32'(o_last));
                    results_checked++;
                    case (want.ev)
                        EV_RELEASED:      n_released++;
                        EV_PACKET_DROP:   n_pkt_drops++;
                        EV_QUEUE_FULL:    n_full_drops++;
                        EV_TOKEN_DROPPED: n_tok_drops++;
                        default: ;
                    endcase
                end
            end
        end
    end

    // Request driver: presents the next pending item once the current one is taken.
    always @(negedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_accepted) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                nxt = pending_reqs.pop_front();
                i_valid         <= 1'b1;
                i_req_type      <= nxt.req;
                i_packet_id     <= nxt.id;
                i_tokens_needed <= nxt.need;
                i_service_time  <= nxt.svc;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is asked for.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no transaction completes for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_request(input logic [ReqW-1:0] req, input logic [IdW-1:0] id,
                                input logic [NeedW-1:0] need, input logic [SvcW-1:0] svc);
        pending_reqs.push_back('{req: req, id: id, need: need, svc: svc});
    endtask

    // Waits until every request is taken and every event has come back.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_valid || due_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One configuration write transaction.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CfgBucketDepth)
            cfg_depth = data[NeedW-1:0];
        else if (idx == CfgPacketsExpected)
            cfg_packets = data[IdW-1:0];
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random request; needs stay mostly within reach of the bucket.
    function automatic t_request make_request(input int tick_pct,
                                              input logic [NeedW-1:0] depth);
        t_request r;
        int       roll;
        int       cap;
        roll   = $urandom_range(0, 99);
        r.id   = IdW'($urandom);
        r.svc  = SvcW'($urandom);
        cap    = (depth < 6) ? int'(depth) : 6;
        if (roll < 4)
            r.req = ReqRestart;
        else if (roll < 4 + tick_pct)
            r.req = ReqTick;
        else
            r.req = ReqArrive;
        case ($urandom_range(0, 9))
            0: begin
                r.need = NeedW'($urandom);
                // A reachable but huge need would block the queue for good.
                if (r.need <= depth && r.need > cap)
                    r.need = NeedW'(int'(r.need) % (cap + 1));
            end
            1: r.need = depth + 1'b1;
            default: r.need = NeedW'($urandom_range(0, cap));
        endcase
        return r;
    endfunction

    // One register setting: drain, write both registers, restart, random traffic.
    task automatic run_phase(input logic [CfgDataW-1:0] depth_word,
                             input logic [CfgDataW-1:0] packets_word,
                             input int tick_pct, input int n_items, input bit hold);
        int taken;
        wait_drained();
        write_reg(CfgBucketDepth, depth_word);
        write_reg(CfgPacketsExpected, packets_word);
        settings_run++;
        if (hold)
            hold_asks++;
        push_request(ReqRestart, '0, '0, '0);
        taken = 0;
        while (taken < n_items) begin
            if ($urandom_range(0, 19) == 0) begin
                push_request(ReqUnused, IdW'($urandom), NeedW'($urandom), SvcW'($urandom));
            end else begin
                pending_reqs.push_back(make_request(tick_pct, depth_word[NeedW-1:0]));
                taken++;
            end
        end
    endtask

    // Test sequence.
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_run = 1;

        snd_idle_pct = 29;
        rcv_idle_pct = 83;

        // Directed part at reset settings: zero need, oversize, release on tick,
        // bucket saturation, an ignored request and a restart.
        push_request(ReqTick,   16'h0000, 10'd0,    16'h0000);
        push_request(ReqArrive, 16'hFFFF, 10'd0,    16'hFFFF);
        push_request(ReqArrive, 16'h0001, 10'd1023, 16'h1234);
        push_request(ReqArrive, 16'h0000, 10'd3,    16'h0000);
        repeat (14) push_request(ReqTick, 16'h0000, 10'd0, 16'h0000);
        push_request(ReqArrive, 16'h5555, 10'd10,   16'hAAAA);
        push_request(ReqUnused, 16'hFFFF, 10'd1023, 16'hFFFF);
        push_request(ReqRestart, 16'h0000, 10'd0,   16'h0000);
        push_request(ReqArrive, 16'hA5A5, 10'd11,   16'h5A5A);

        // Sender idles lightly, receiver heavily.
        run_phase(16'd10, 16'd20, 50, 120, 1'b0);
        run_phase(16'd1023, 16'hFFFF, 60, 100, 1'b0);

        // Roles swapped; zero depth, then a single token with no packets left.
        wait_drained();
        snd_idle_pct = 83;
        rcv_idle_pct = 29;
        run_phase(16'hFC00, 16'd5, 40, 100, 1'b0);
        run_phase(16'd1, 16'd0, 30, 100, 1'b0);

        // No idling; a long receiver hold-off backs the block up first.
        wait_drained();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(16'd4, 16'd30, 45, 150, 1'b1);
        run_phase({6'($urandom), 10'd1023}, 16'($urandom), 55, 130, 1'b0);

        wait_drained();
        $display("Checked %0d results from %0d requests over %0d settings (%0d writes).",
                 results_checked, reqs_taken, settings_run, cfg_writes);
        $display("Releases %0d, oversize drops %0d, queue-full drops %0d, token drops %0d.",
                 n_released, n_pkt_drops, n_full_drops, n_tok_drops);
        if (errors == 0 && due_events.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
